### src/vsp_pkg.sv
package vsp_pkg;

  // voxel width
  localparam int VOX_W = 8;

  // widest configuration register
  localparam int CFG_W = 13;

  // filter modes
  localparam logic [1:0] MODE_MAX  = 2'd0;
  localparam logic [1:0] MODE_MIN  = 2'd1;
  localparam logic [1:0] MODE_MEAN = 2'd2;
  localparam logic [1:0] MODE_PASS = 2'd3;

  // register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_SIZE_X = 2'd1;
  localparam logic [1:0] REG_SIZE_Y = 2'd2;
  localparam logic [1:0] REG_SIZE_Z = 2'd3;

  // sum of seven voxels and division by seven as multiply and shift
  localparam int SUM_W      = 11;
  localparam int DIV7_MUL_W = 12;
  localparam int DIV7_SHIFT = 14;
  localparam logic [DIV7_MUL_W-1:0] DIV7_MUL = 12'd2341;

  // seven point window with the in-volume flag of each face neighbour
  typedef struct packed {
    logic [VOX_W-1:0] centre;
    logic [VOX_W-1:0] x_lo;
    logic [VOX_W-1:0] x_hi;
    logic [VOX_W-1:0] y_lo;
    logic [VOX_W-1:0] y_hi;
    logic [VOX_W-1:0] z_lo;
    logic [VOX_W-1:0] z_hi;
    logic             x_lo_ok;
    logic             x_hi_ok;
    logic             y_lo_ok;
    logic             y_hi_ok;
    logic             z_lo_ok;
    logic             z_hi_ok;
  } window_t;

endpackage

### src/vsp_reduce.sv
module vsp_reduce (
  input  logic [1:0]                mode,
  input  vsp_pkg::window_t          win,
  output logic [vsp_pkg::VOX_W-1:0] result
);
  import vsp_pkg::*;

  logic [VOX_W-1:0] nb [6];
  logic [VOX_W-1:0] hi_v;
  logic [VOX_W-1:0] lo_v;
  logic [SUM_W-1:0] sum;
  logic [SUM_W+DIV7_MUL_W-1:0] prod;

  // outside neighbours read as the centre
  always_comb begin
    nb[0] = win.x_lo_ok ? win.x_lo : win.centre;
    nb[1] = win.x_hi_ok ? win.x_hi : win.centre;
    nb[2] = win.y_lo_ok ? win.y_lo : win.centre;
    nb[3] = win.y_hi_ok ? win.y_hi : win.centre;
    nb[4] = win.z_lo_ok ? win.z_lo : win.centre;
    nb[5] = win.z_hi_ok ? win.z_hi : win.centre;
  end

  // maximum, minimum and sum over the window
  always_comb begin
    hi_v = win.centre;
    lo_v = win.centre;
    sum  = SUM_W'(win.centre);
    for (int i = 0; i < 6; i++) begin
      if (nb[i] > hi_v) hi_v = nb[i];
      if (nb[i] < lo_v) lo_v = nb[i];
      sum = sum + SUM_W'(nb[i]);
    end
  end

  // floor of sum over seven
  assign prod = SUM_W'(sum) * DIV7_MUL;

  always_comb begin
    case (mode)
      MODE_MAX:  result = hi_v;
      MODE_MIN:  result = lo_v;
      MODE_MEAN: result = VOX_W'(prod >> DIV7_SHIFT);
      default:   result = win.centre;
    endcase
  end

endmodule

### src/voxel_seven_point_stencil_filter_core.sv
// Seven point voxel filter: takes one voxel item per cycle in raster order and
// gives one result item per cycle once the pipeline is filled, a result
// trailing its input by one plane, one line and one voxel pushed through the
// delay lines. The rate is set by a plane delay RAM (depth of the largest
// plane, 16 bits wide) and a line delay RAM (depth of the longest line, 32 bits
// wide), each written and read once per voxel. Once the last voxel of a volume
// is in, the input is held until the delay lines have been stepped to the first
// pending result, after which each flush item gives one result per cycle. A write
// to a size register holds the input in the cycle after the write. Output
// back-pressure stalls the pipeline without losing an item.
module voxel_seven_point_stencil_filter_core #(
  parameter int MAX_SIZE_X = 64,
  parameter int MAX_SIZE_Y = 64,
  parameter int MAX_SIZE_Z = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // voxel_value
  input  logic                      s_tuser,   // flush
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [7:0]                m_tdata,   // filtered_value
  output logic                      m_tlast,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [vsp_pkg::CFG_W-1:0] cfg_data
);
  import vsp_pkg::*;

  localparam int SXW       = $clog2(MAX_SIZE_X + 1);
  localparam int SYW       = $clog2(MAX_SIZE_Y + 1);
  localparam int SZW       = $clog2(MAX_SIZE_Z + 1);
  localparam int XW        = (MAX_SIZE_X > 1) ? $clog2(MAX_SIZE_X) : 1;
  localparam int YW        = (MAX_SIZE_Y > 1) ? $clog2(MAX_SIZE_Y) : 1;
  localparam int PLANE_MAX = MAX_SIZE_X * MAX_SIZE_Y;
  localparam int PW        = $clog2(PLANE_MAX + 1);
  localparam int PAW       = (PLANE_MAX > 1) ? $clog2(PLANE_MAX) : 1;
  localparam int PD        = 1 << PAW;
  localparam int LAW       = XW;
  localparam int LD        = 1 << LAW;
  localparam int LGW       = $clog2(PLANE_MAX + MAX_SIZE_X + 2);

  // configuration registers
  logic [1:0]  mode;
  logic [6:0]  size_x;
  logic [6:0]  size_y;
  logic [12:0] size_z;
  logic        cfg_hold;

  logic [SXW-1:0] sx_eff;
  logic [SYW-1:0] sy_eff;
  logic [SZW-1:0] sz_eff;
  logic [PW-1:0]  plane;
  logic [LGW-1:0] lag;

  // counters
  logic [XW-1:0]  in_x;
  logic [YW-1:0]  in_y;
  logic [SZW-1:0] in_z;
  logic [XW-1:0]  ox;
  logic [YW-1:0]  oy;
  logic [SZW-1:0] oz;
  logic [LGW-1:0] fill;
  logic [PAW-1:0] pwp;
  logic [LAW-1:0] lwp;

  // delay memories and taps
  logic [15:0]      plane_mem [PD];
  logic [15:0]      plane_rd;
  logic [31:0]      line_mem [LD];
  logic [31:0]      line_rd;
  logic [PAW-1:0]   p_raddr;
  logic [LAW-1:0]   l_raddr;
  logic [VOX_W-1:0] r1, r2, d_zp, d_yp, d_ym, d_zm;

  window_t          win;
  logic             win_valid;
  logic             win_last;
  logic [VOX_W-1:0] result;

  logic in_done, out_done, primed, out_load, move_ok;
  logic acc, vox_push, fl_push, auto_push, push;
  logic [VOX_W-1:0] push_data;
  logic x_hi_ok, y_hi_ok, z_hi_ok;

  // effective sizes, out of range values clamped
  always_comb begin
    if (size_x == '0) sx_eff = SXW'(1);
    else if (32'(size_x) > MAX_SIZE_X) sx_eff = SXW'(MAX_SIZE_X);
    else sx_eff = SXW'(size_x);
    if (size_y == '0) sy_eff = SYW'(1);
    else if (32'(size_y) > MAX_SIZE_Y) sy_eff = SYW'(MAX_SIZE_Y);
    else sy_eff = SYW'(size_y);
    if (size_z == '0) sz_eff = SZW'(1);
    else if (32'(size_z) > MAX_SIZE_Z) sz_eff = SZW'(MAX_SIZE_Z);
    else sz_eff = SZW'(size_z);
  end

  // plane size and pipeline lag follow the effective sizes through a register
  always_ff @(posedge clk) begin
    plane <= PW'(32'(sx_eff) * 32'(sy_eff));
    lag   <= LGW'(32'(sx_eff) * 32'(sy_eff) + 32'(sx_eff) + 32'd1);
  end

  // configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_MAX;
      size_x   <= 7'd32;
      size_y   <= 7'd32;
      size_z   <= 13'd32;
      cfg_hold <= 1'b0;
    end else begin
      cfg_hold <= cfg_we && (cfg_index != REG_MODE);
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:   mode   <= cfg_data[1:0];
          REG_SIZE_X: size_x <= cfg_data[6:0];
          REG_SIZE_Y: size_y <= cfg_data[6:0];
          REG_SIZE_Z: size_z <= cfg_data;
          default:    mode   <= mode;
        endcase
      end
    end
  end

  // handshake and push control
  assign in_done   = (in_z == sz_eff);
  assign out_done  = (oz == sz_eff);
  assign primed    = (fill == lag);
  assign out_load  = win_valid && (!m_tvalid || m_tready);
  assign move_ok   = !win_valid || out_load;
  assign s_tready  = !cfg_hold && move_ok && (!in_done || primed);
  assign acc       = s_tvalid && s_tready;
  assign vox_push  = acc && !s_tuser && !in_done;
  assign fl_push   = acc && s_tuser && in_done && !out_done;
  assign auto_push = !cfg_hold && !cfg_we && in_done && !primed && move_ok;
  assign push      = vox_push || fl_push || auto_push;
  assign push_data = vox_push ? s_tdata : '0;

  // neighbour flags of the next result
  assign x_hi_ok = (SXW'(ox) + SXW'(1)) != sx_eff;
  assign y_hi_ok = (SYW'(oy) + SYW'(1)) != sy_eff;
  assign z_hi_ok = (oz + SZW'(1)) != sz_eff;

  // counters and window valid
  always_ff @(posedge clk) begin
    if (rst || (cfg_we && cfg_index != REG_MODE)) begin
      in_x      <= '0;
      in_y      <= '0;
      in_z      <= '0;
      ox        <= '0;
      oy        <= '0;
      oz        <= '0;
      fill      <= '0;
      pwp       <= '0;
      lwp       <= '0;
      win_valid <= 1'b0;
    end else begin
      if (vox_push) begin
        if (SXW'(in_x) + SXW'(1) == sx_eff) begin
          in_x <= '0;
          if (SYW'(in_y) + SYW'(1) == sy_eff) begin
            in_y <= '0;
            in_z <= in_z + SZW'(1);
          end else begin
            in_y <= in_y + YW'(1);
          end
        end else begin
          in_x <= in_x + XW'(1);
        end
      end
      if (push) begin
        pwp       <= pwp + PAW'(1);
        lwp       <= lwp + LAW'(1);
        win_valid <= primed;
        if (!primed) fill <= fill + LGW'(1);
        if (primed) begin
          if (!x_hi_ok) begin
            ox <= '0;
            if (!y_hi_ok) begin
              oy <= '0;
              oz <= oz + SZW'(1);
            end else begin
              oy <= oy + YW'(1);
            end
          end else begin
            ox <= ox + XW'(1);
          end
        end
      end else if (out_load) begin
        win_valid <= 1'b0;
      end
    end
  end

  // plane delay: word holds the input and its one-plane delayed copy
  assign p_raddr = pwp - PAW'(plane - PW'(1));

  always_ff @(posedge clk) begin
    if (push) begin
      plane_mem[pwp] <= {plane_rd[7:0], push_data};
      if (plane == PW'(1)) plane_rd <= {plane_rd[7:0], push_data};
      else plane_rd <= plane_mem[p_raddr];
    end
  end

  // line delay over the plane taps, with the centre line fed back once more
  assign l_raddr = lwp - LAW'(sx_eff - SXW'(1));

  always_ff @(posedge clk) begin
    if (push) begin
      line_mem[lwp] <= {line_rd[15:8], plane_rd[15:8], plane_rd[7:0], push_data};
      if (sx_eff == SXW'(1)) begin
        line_rd <= {line_rd[15:8], plane_rd[15:8], plane_rd[7:0], push_data};
      end else begin
        line_rd <= line_mem[l_raddr];
      end
    end
  end

  // one voxel alignment and window capture
  always_ff @(posedge clk) begin
    if (push) begin
      r1          <= line_rd[15:8];
      r2          <= r1;
      d_zp        <= line_rd[7:0];
      d_yp        <= plane_rd[7:0];
      d_ym        <= line_rd[31:24];
      d_zm        <= line_rd[23:16];
      win.x_hi    <= line_rd[15:8];
      win.centre  <= r1;
      win.x_lo    <= r2;
      win.z_hi    <= d_zp;
      win.y_hi    <= d_yp;
      win.y_lo    <= d_ym;
      win.z_lo    <= d_zm;
      win.x_lo_ok <= (ox != '0);
      win.x_hi_ok <= x_hi_ok;
      win.y_lo_ok <= (oy != '0);
      win.y_hi_ok <= y_hi_ok;
      win.z_lo_ok <= (oz != '0);
      win.z_hi_ok <= z_hi_ok;
      win_last    <= !x_hi_ok && !y_hi_ok && !z_hi_ok;
    end
  end

  vsp_reduce u_reduce (
    .mode   (mode),
    .win    (win),
    .result (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= result;
      m_tlast <= win_last;
    end
  end

endmodule

### src/vsp_checker.sv
module vsp_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       cfg_we,
  input logic [1:0] cfg_index
);
  import vsp_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result item changed while stalled");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result item present after reset");

  // a size write holds the input in the next cycle
  a_size_hold: assert property (@(posedge clk) disable iff (rst)
    cfg_we && cfg_index != REG_MODE |=> !s_tready)
    else $error("input taken right after a size write");

  // nothing follows the final voxel of a volume
  a_after_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid)
    else $error("result item after the final voxel");

endmodule

bind voxel_seven_point_stencil_filter_core vsp_checker u_vsp_checker (.*);

### bench/tb_voxel_seven_point_stencil_filter_core.sv
import vsp_pkg::*;

typedef struct packed {
  logic [VOX_W-1:0] value;
  logic             last;
} voxel_result_t;

// tracks the volume as the block should see it and holds the results still owed
class stencil_scoreboard;
  logic [VOX_W-1:0] ring [16384];
  int unsigned in_x, in_y, in_z, out_x, out_y, out_z;
  int unsigned size_x, size_y, size_z;
  logic [1:0] mode;
  voxel_result_t owed [$];
  int mismatches;

  function new();
    mode = MODE_MAX;
    size_x = 32;
    size_y = 32;
    size_z = 32;
    mismatches = 0;
    restart();
  endfunction

  function void restart();
    in_x = 0; in_y = 0; in_z = 0;
    out_x = 0; out_y = 0; out_z = 0;
  endfunction

  function int unsigned clamp(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function int unsigned sx(); return clamp(size_x, 64); endfunction
  function int unsigned sy(); return clamp(size_y, 64); endfunction
  function int unsigned sz(); return clamp(size_z, 4096); endfunction

  function int unsigned voxel_count(); return sx() * sy() * sz(); endfunction
  function int unsigned settle_cycles(); return sx() * sy() + sx() + 30; endfunction
  function bit volume_done(); return out_z >= sz(); endfunction

  function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] v);
    case (idx)
      REG_MODE:   mode = v[1:0];
      REG_SIZE_X: begin size_x = v[6:0]; restart(); end
      REG_SIZE_Y: begin size_y = v[6:0]; restart(); end
      REG_SIZE_Z: begin size_z = v[12:0]; restart(); end
      default: ;
    endcase
  endfunction

  function logic [VOX_W-1:0] at(longint unsigned lin);
    return ring[lin % 16384];
  endfunction

  function void step(longint unsigned ref_x, longint unsigned ref_y,
                     inout int unsigned x, inout int unsigned y, inout int unsigned z);
    x++;
    if (x >= ref_x) begin
      x = 0;
      y++;
      if (y >= ref_y) begin
        y = 0;
        z++;
      end
    end
  endfunction

  // seven point reduction of the next voxel due out
  function void reduce_next();
    longint unsigned plane, o;
    logic [VOX_W-1:0] self;
    logic [VOX_W-1:0] nb [6];
    int unsigned r;
    voxel_result_t res;
    plane = sx() * sy();
    o = (longint'(out_z) * sy() + out_y) * sx() + out_x;
    self = at(o);
    nb[0] = (out_x > 0) ? at(o - 1) : self;
    nb[1] = (out_x + 1 < sx()) ? at(o + 1) : self;
    nb[2] = (out_y > 0) ? at(o - sx()) : self;
    nb[3] = (out_y + 1 < sy()) ? at(o + sx()) : self;
    nb[4] = (out_z > 0) ? at(o - plane) : self;
    nb[5] = (out_z + 1 < sz()) ? at(o + plane) : self;
    r = self;
    case (mode)
      MODE_MAX:  foreach (nb[i]) if (nb[i] > r) r = nb[i];
      MODE_MIN:  foreach (nb[i]) if (nb[i] < r) r = nb[i];
      MODE_MEAN: begin
        foreach (nb[i]) r += nb[i];
        r = r / 7;
      end
      default: ;
    endcase
    res.value = r[7:0];
    res.last = (out_x + 1 == sx()) && (out_y + 1 == sy()) && (out_z + 1 == sz());
    owed.insert(owed.size(), res);
    step(sx(), sy(), out_x, out_y, out_z);
  endfunction

  // accepted input item
  function void note_item(bit flush, logic [VOX_W-1:0] v);
    longint unsigned n_in, o, lag;
    lag = sx() * sy() + sx() + 1;
    if (out_z >= sz()) return;
    if (flush) begin
      if (in_z < sz()) return;
      reduce_next();
      return;
    end
    if (in_z >= sz()) return;
    n_in = (longint'(in_z) * sy() + in_y) * sx() + in_x;
    ring[n_in % 16384] = v;
    step(sx(), sy(), in_x, in_y, in_z);
    o = (longint'(out_z) * sy() + out_y) * sx() + out_x;
    if (n_in + 1 > o + lag) reduce_next();
  endfunction

  // accepted result item
  function void check(logic [VOX_W-1:0] v, logic last);
    voxel_result_t e;
    if (owed.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result value %0d last %0d", v, last);
      return;
    end
    e = owed.pop_front();
    if (e.value !== v || e.last !== last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected value %0d last %0d, got value %0d last %0d",
                 e.value, e.last, v, last);
    end
  endfunction
endclass

module tb_voxel_seven_point_stencil_filter_core;
  localparam int CYCLE_LIMIT = 2000000;

  logic             clk;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = '0;  // voxel_value
  logic             s_tuser = 1'b0; // flush
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [7:0]       m_tdata;  // filtered_value
  logic             m_tlast;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  stencil_scoreboard sb = new();

  voxel_seven_point_stencil_filter_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // long stretch without idling on either side
  function automatic bit quiet();
    return cycles >= 20000 && cycles < 40000;
  endfunction

  // cycle count and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side with random stalls
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check(m_tdata, m_tlast);
    m_tready <= quiet() || ($urandom_range(99) >= 6);
  end

  task automatic send_item(bit flush, logic [7:0] v);
    s_tvalid <= 1'b1;
    s_tdata <= v;
    s_tuser <= flush;
    do @(posedge clk); while (!s_tready);
    sb.note_item(flush, v);
    items_sent++;
    if (!quiet() && $urandom_range(99) < 6) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // stop sending and wait for every owed result
  task automatic wait_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_results();
    repeat (sb.settle_cycles()) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  // one volume: set up, stream voxels, drain with flush items, then ignored items if noise is set
  task automatic run_volume(logic [1:0] mode, int unsigned x, int unsigned y,
                            int unsigned z, bit binary, bit noise, bit pause,
                            bit split);
    int unsigned n;
    int unsigned k;
    logic [7:0] v;
    settle();
    write_reg(REG_MODE, CFG_W'({$urandom_range(2047), mode}));
    write_reg(REG_SIZE_X, CFG_W'({$urandom_range(63), x[6:0]}));
    write_reg(REG_SIZE_Y, CFG_W'({$urandom_range(63), y[6:0]}));
    write_reg(REG_SIZE_Z, z[12:0]);
    n = sb.voxel_count();
    for (int unsigned i = 0; i < n; i++) begin
      if (noise && $urandom_range(99) < 4) send_item(1'b1, 8'($urandom));
      if (pause && i == n / 2) wait_results();
      v = binary ? ($urandom_range(1) ? 8'hff : 8'h00) : 8'($urandom);
      send_item(1'b0, v);
    end
    k = 0;
    while (!sb.volume_done()) begin
      // filter mode changed part way through the drain
      if (split && k == 2) begin
        settle();
        write_reg(REG_MODE, CFG_W'($urandom_range(3)));
      end
      send_item(1'b1, 8'($urandom));
      k++;
    end
    if (noise) begin
      send_item(1'b0, 8'($urandom));
      send_item(1'b1, 8'($urandom));
    end
  endtask

  initial begin
    int unsigned target;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: each mode, saturated values, degenerate and clamped sizes
    run_volume(MODE_MAX, 3, 3, 2, 1, 1, 0, 0);
    run_volume(MODE_MIN, 3, 2, 2, 1, 0, 1, 0);
    run_volume(MODE_MEAN, 2, 2, 2, 1, 0, 0, 1);
    run_volume(MODE_PASS, 1, 1, 1, 0, 1, 0, 0);
    run_volume(MODE_MEAN, 0, 0, 0, 0, 1, 0, 0);
    run_volume(MODE_MAX, 127, 1, 2, 0, 0, 0, 1);
    run_volume(MODE_MEAN, 1, 100, 2, 1, 0, 0, 0);
    run_volume(MODE_MIN, 8, 8, 3, 0, 0, 1, 0);
    run_volume(MODE_MEAN, 1, 1, 9, 0, 1, 0, 0);

    // random volumes, mostly small
    target = 1050;
    while (items_sent < target)
      run_volume(2'($urandom_range(3)), $urandom_range(9), $urandom_range(6),
                 $urandom_range(5), $urandom_range(3) == 0, $urandom_range(1) == 1,
                 $urandom_range(9) < 3, $urandom_range(3) == 0);

    settle();
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
